// ===== rtl/gtep_pkg.sv =====
`default_nettype none
package gtep_pkg;

  localparam int POS_W      = 16;  // message position width
  localparam int TAG_W      = 8;
  localparam int OUT_W      = 16;  // offset / length / count width on the result beat
  localparam int REM_W      = 17;  // bytes remaining and step length
  localparam int TAG_COUNT  = 256;
  localparam int TAG_IDX_W  = $clog2(TAG_COUNT);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  // Configuration register indexes
  localparam logic CFG_FIRST_LV  = 1'b0;
  localparam logic CFG_SECOND_LV = 1'b1;

  // Result kinds
  localparam logic KIND_ELEM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_LEN  = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  typedef enum logic [2:0] {
    PH_LV1     = 3'd0,
    PH_LV2     = 3'd1,
    PH_TAG     = 3'd2,
    PH_LEN     = 3'd3,
    PH_LENLO   = 3'd4,
    PH_VAL_LV2 = 3'd5,
    PH_VAL_TAG = 3'd6,
    PH_SKIP    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    TY_UNKNOWN = 3'd0,
    TY_T       = 3'd1,
    TY_TV      = 3'd2,
    TY_FIXED   = 3'd3,
    TY_TLV     = 3'd4,
    TY_TL16V   = 3'd5
  } ie_type_t;

  typedef struct packed {
    logic [7:0] stored_len;
    logic [2:0] typ;
  } tag_def_t;

  typedef struct packed {
    logic             last;
    logic             kind;
    logic [1:0]       status;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] len;
    logic [OUT_W-1:0] off;
    logic [TAG_W-1:0] tag;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/gsm_tlv_element_parser_unit.sv =====
`default_nettype none
// Streaming parser for tag/length/value information elements. Message bytes enter
// as in_ beats with in_tuser = 0 (in_tlast marks the final byte); a beat with
// in_tuser = 1 loads one entry of the 256-entry tag definition store, which reset
// clears to "unknown" through per-entry valid flags (no clearing pass, the block is
// ready right after reset). Up to two leading LV elements are taken from the tags in
// configuration registers 0 and 1 (zero disables one). Each element is reported as
// one out_ beat on the byte that completes it; the final byte adds a summary beat
// (out_tuser = 1, out_tlast = 1) with the element count and status (1 length byte
// missing, 2 value overruns the message). Rate: one input beat per clock while
// in_tready is high. Path: the input register, which also holds the registered
// definition read, then a four-entry result queue. A final byte that also completes
// an element pushes two beats; the queue drains one beat per clock while out_tready
// is high, so in_tready drops only when over two results wait. The user must write
// configuration only while the block is idle (not enforced); cfg_ready is always high.
module gsm_tlv_element_parser_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // config write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [7:0]                    cfg_data,
  // input beats
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [7:0] data_byte, [15:8] def_tag, [18:16] def_type, [26:19] def_fixed_len, rest 0
  input  wire logic [gtep_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                          in_tuser,  // cmd
  input  wire logic                          in_tlast,  // last_byte
  // result beats
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] elem_tag, [23:8] value_offset, [39:24] value_length,
  // [55:40] element_count, [57:56] status, rest 0
  output logic [gtep_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser, // kind
  output logic                               out_tlast  // last_result
);
  import gtep_pkg::*;

  // ---------------- configuration ----------------
  logic [TAG_W-1:0] first_lv_r, second_lv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_lv_r  <= '0;
      second_lv_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_LV:  first_lv_r  <= cfg_data;
        CFG_SECOND_LV: second_lv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input beat fields ----------------
  logic [7:0]           in_byte;
  logic [TAG_IDX_W-1:0] in_def_tag;
  logic [2:0]           in_def_type;
  logic [7:0]           in_def_len;
  logic                 in_fire;

  assign in_byte     = in_tdata[7:0];
  assign in_def_tag  = in_tdata[15:8];
  assign in_def_type = in_tdata[18:16];
  assign in_def_len  = in_tdata[26:19];
  assign in_fire     = in_tvalid && in_tready;

  // ---------------- tag definition store ----------------
  tag_def_t            def_mem [TAG_COUNT];
  logic [TAG_COUNT-1:0] def_vld_r;
  tag_def_t            def_rd_r;
  logic                def_rd_vld_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser) begin
      def_mem[in_def_tag] <= '{stored_len: in_def_len, typ: in_def_type};
    end
    if (in_fire) begin
      def_rd_r <= def_mem[in_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_vld_r    <= '0;
      def_rd_vld_r <= 1'b0;
    end else if (in_fire) begin
      def_rd_vld_r <= def_vld_r[in_byte];
      if (in_tuser) def_vld_r[in_def_tag] <= 1'b1;
    end
  end

  // ---------------- input register ----------------
  logic       s1_vld_r;
  logic       s1_cmd_r, s1_last_r;
  logic [7:0] s1_byte_r;
  logic [2:0] q_cnt_r;
  logic       proc;

  assign proc      = s1_vld_r && (q_cnt_r <= 3'd2);  // room for two results
  assign in_tready = !s1_vld_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_last_r <= in_tlast;
      s1_byte_r <= in_byte;
    end
  end

  // ---------------- parse state ----------------
  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TAG_W-1:0] cur_tag_r, cur_tag_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] vstart_r, vstart_nxt;
  logic [REM_W-1:0] prev_len_r, prev_len_nxt;
  logic [OUT_W-1:0] count_r, count_nxt;

  tag_def_t         def;
  logic [POS_W-1:0] pos_inc;
  logic             do_tag, lv_go, lv_after1, vk_go;
  logic [TAG_W-1:0] lv_tag;
  logic [POS_W-1:0] vk_len;
  logic [REM_W-1:0] rem_dec;
  logic             rep;
  logic [POS_W-1:0] rep_off, rep_len;
  logic [1:0]       sum_status;
  logic [OUT_W-1:0] elem_cnt;
  logic             sum_go;
  result_t          res0, res1;
  logic [1:0]       push_n;

  assign def     = def_rd_vld_r ? def_rd_r : '0;
  assign pos_inc = pos_r + POS_W'(1);
  assign rem_dec = (rem_r != '0) ? rem_r - REM_W'(1) : '0;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_inc;
    cur_tag_nxt  = cur_tag_r;
    rem_nxt      = rem_r;
    vstart_nxt   = vstart_r;
    prev_len_nxt = prev_len_r;
    count_nxt    = count_r;
    do_tag       = 1'b0;
    lv_go        = 1'b0;
    lv_after1    = 1'b0;
    lv_tag       = '0;
    vk_go        = 1'b0;
    vk_len       = '0;
    rep          = 1'b0;
    rep_off      = '0;
    rep_len      = '0;
    sum_status   = ST_OK;
    sum_go       = 1'b0;

    case (phase_r)
      PH_LV1: begin
        if (first_lv_r != '0) begin
          lv_go = 1'b1; lv_after1 = 1'b1; lv_tag = first_lv_r;
        end else if (second_lv_r != '0) begin
          lv_go = 1'b1; lv_tag = second_lv_r;
        end else begin
          do_tag = 1'b1;
        end
      end
      PH_LV2: begin
        if (second_lv_r != '0) begin
          lv_go = 1'b1; lv_tag = second_lv_r;
        end else begin
          do_tag = 1'b1;
        end
      end
      PH_TAG: do_tag = 1'b1;
      PH_LEN: begin
        if (rem_r == '0) begin
          prev_len_nxt = REM_W'(s1_byte_r) + REM_W'(2);
          vk_go  = 1'b1;
          vk_len = POS_W'(s1_byte_r);
        end else begin
          rem_nxt   = {1'b0, s1_byte_r, 8'h00};
          phase_nxt = PH_LENLO;
        end
      end
      PH_LENLO: begin
        prev_len_nxt = REM_W'({rem_r[15:8], s1_byte_r}) + REM_W'(3);
        vk_go  = 1'b1;
        vk_len = {rem_r[15:8], s1_byte_r};
      end
      PH_VAL_LV2, PH_VAL_TAG: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = (phase_r == PH_VAL_LV2) ? PH_LV2 : PH_TAG;
          rep       = 1'b1;
          rep_off   = vstart_r;
          rep_len   = pos_inc - vstart_r;
        end
      end
      default: begin  // skipping an unknown element
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_TAG;
      end
    endcase

    // leading LV length byte
    if (lv_go) begin
      cur_tag_nxt  = lv_tag;
      prev_len_nxt = REM_W'(s1_byte_r) + REM_W'(1);
      vstart_nxt   = pos_inc;
      if (s1_byte_r == '0) begin
        phase_nxt = lv_after1 ? PH_LV2 : PH_TAG;
        rep       = 1'b1;
        rep_off   = pos_inc;
      end else begin
        rem_nxt   = REM_W'(s1_byte_r);
        phase_nxt = lv_after1 ? PH_VAL_LV2 : PH_VAL_TAG;
      end
    end

    // tag byte, looked up in the definition store
    if (do_tag) begin
      cur_tag_nxt = s1_byte_r;
      case (ie_type_t'(def.typ))
        TY_T: begin
          prev_len_nxt = REM_W'(1);
          rep          = 1'b1;
          rep_off      = pos_r;
        end
        TY_TV: begin
          prev_len_nxt = REM_W'(2);
          vk_go        = 1'b1;
          vk_len       = POS_W'(1);
        end
        TY_FIXED: begin
          prev_len_nxt = REM_W'(def.stored_len) + REM_W'(1);
          vk_go        = 1'b1;
          vk_len       = POS_W'(def.stored_len);
        end
        TY_TLV: begin
          rem_nxt   = '0;
          phase_nxt = PH_LEN;
        end
        TY_TL16V: begin
          rem_nxt   = REM_W'(1);
          phase_nxt = PH_LEN;
        end
        default: begin  // unknown: skip by the previous step length
          if (prev_len_r > REM_W'(1)) begin
            rem_nxt   = prev_len_r - REM_W'(1);
            phase_nxt = PH_SKIP;
          end
        end
      endcase
    end

    // value length now known
    if (vk_go) begin
      vstart_nxt = pos_inc;
      if (vk_len == '0) begin
        phase_nxt = PH_TAG;
        rep       = 1'b1;
        rep_off   = pos_inc;
      end else begin
        rem_nxt   = REM_W'(vk_len);
        phase_nxt = PH_VAL_TAG;
      end
    end

    elem_cnt = count_r + OUT_W'(1);
    if (rep) count_nxt = elem_cnt;

    // end of message: summary and clear
    if (s1_last_r) begin
      sum_go = 1'b1;
      case (phase_nxt)
        PH_LV2:                 sum_status = (second_lv_r != '0) ? ST_NO_LEN : ST_OK;
        PH_LEN, PH_LENLO:       sum_status = ST_NO_LEN;
        PH_VAL_LV2, PH_VAL_TAG: sum_status = ST_OVERRUN;
        default:                sum_status = ST_OK;
      endcase
    end

    res1 = '{last: 1'b1, kind: KIND_SUMMARY, status: sum_status, count: count_nxt,
             len: '0, off: '0, tag: '0};
    if (rep) begin
      res0 = '{last: 1'b0, kind: KIND_ELEM, status: ST_OK, count: elem_cnt,
               len: OUT_W'(rep_len), off: OUT_W'(rep_off), tag: cur_tag_nxt};
    end else begin
      res0 = res1;
    end

    if (sum_go) begin
      phase_nxt    = PH_LV1;
      pos_nxt      = '0;
      cur_tag_nxt  = '0;
      rem_nxt      = '0;
      vstart_nxt   = '0;
      prev_len_nxt = REM_W'(1);
      count_nxt    = '0;
    end

    if (proc && !s1_cmd_r) begin
      push_n = 2'(rep) + 2'(sum_go);
    end else begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LV1;
      pos_r      <= '0;
      cur_tag_r  <= '0;
      rem_r      <= '0;
      vstart_r   <= '0;
      prev_len_r <= REM_W'(1);
      count_r    <= '0;
    end else if (proc && !s1_cmd_r) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      cur_tag_r  <= cur_tag_nxt;
      rem_r      <= rem_nxt;
      vstart_r   <= vstart_nxt;
      prev_len_r <= prev_len_nxt;
      count_r    <= count_nxt;
    end
  end

  // ---------------- result queue ----------------
  result_t            q_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] q_wr_r, q_rd_r;
  logic               pop;
  result_t            q_head;

  assign pop    = out_tvalid && out_tready;
  assign q_head = q_mem_r[q_rd_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem_r[q_wr_r] <= res0;
    if (push_n == 2'd2) q_mem_r[q_wr_r + FIFO_AW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + FIFO_AW'(push_n);
      q_rd_r  <= q_rd_r + FIFO_AW'(pop);
      q_cnt_r <= q_cnt_r + 3'(push_n) - 3'(pop);
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = q_head.kind;
  assign out_tlast  = q_head.last;
  assign out_tdata  = {6'd0, q_head.status, q_head.count, q_head.len, q_head.off,
                       q_head.tag};

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_cmd_r) |-> (push_n == 2'd0))
    else $error("definition load produced a result");

  a_two_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (s1_last_r && !s1_cmd_r))
    else $error("two results without a final byte");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !s1_cmd_r && s1_last_r) |=> (phase_r == PH_LV1 && pos_r == '0 && count_r == '0))
    else $error("message state not cleared after final byte");

  a_elem_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ELEM) |-> (q_head.status == ST_OK && !out_tlast))
    else $error("element beat carries summary fields");
`endif

endmodule
`default_nettype wire
